[src/acmn_pkg.sv]
// Shared constants, types and controller encodings for the min/max normalizer.
`default_nettype none
package acmn_pkg;

	localparam int CHAN_W           = 4;
	localparam int BYTE_W           = 8;
	localparam int RAW_W            = 16;
	localparam int FRAC_W           = 17;
	localparam int COUNT_W          = 5;
	localparam int MAX_CHANNELS_DEF = 16;
	localparam int DIV_STEPS        = 17;
	localparam int DIV_CNT_W        = 5;

	localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd5;
	localparam logic [RAW_W-1:0]   MIN_RESET   = 16'hFFFF;
	localparam logic [RAW_W-1:0]   MAX_RESET   = 16'h0000;

	typedef logic [CHAN_W-1:0]  chan_t;
	typedef logic [BYTE_W-1:0]  byte_t;
	typedef logic [RAW_W-1:0]   raw_t;
	typedef logic [FRAC_W-1:0]  frac_t;
	typedef logic [COUNT_W-1:0] count_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOK,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic update;
		logic step;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic active;
		logic div_done;
		logic out_free;
	} status_t;

endpackage
`default_nettype wire

[src/acmn_if.sv]
// Valid/ready channel interfaces for samples and normalized results.
`default_nettype none
interface acmn_in_if;
	logic            valid;
	logic            ready;
	acmn_pkg::chan_t channel;
	acmn_pkg::byte_t high_byte;
	acmn_pkg::byte_t low_byte;

	modport source (output valid, output channel, output high_byte, output low_byte,
		input ready);
	modport sink (input valid, input channel, input high_byte, input low_byte,
		output ready);
endinterface

interface acmn_out_if;
	logic            valid;
	logic            ready;
	acmn_pkg::chan_t out_channel;
	acmn_pkg::frac_t fraction;
	logic            calibrated;

	modport source (output valid, output out_channel, output fraction,
		output calibrated, input ready);
	modport sink (input valid, input out_channel, input fraction, input calibrated,
		output ready);
endinterface
`default_nettype wire

[src/autocal_minmax_normalizer.sv]
// Top level of the auto-calibrating min/max sensor normalizer.
//
//   Channel  Direction  Handshake        Contents
//   sample   in         valid/ready      channel, high_byte, low_byte
//   result   out        valid/ready      out_channel, fraction, calibrated
//   cfg      in         cfg_we only      channel_count (5 bits)
//
// After an item is accepted, the channel's limits are read from the limit RAM and
// updated, the serial restoring divider runs its 17 steps, then a check and the
// load of the result register follow. The next item is accepted only once the
// controller is back in idle, so no item is taken before the last one is through.
// An item on an inactive channel is dropped in the lookup state with no result.
// Reset clears the state machine, the per-channel written flags (so every
// channel starts with min 65535 and max 0) and sets channel_count to 5.
// A stalled result holds in the result register; the next item can be
// accepted while it waits, and its own result waits until the register frees.
`default_nettype none
module autocal_minmax_normalizer #(
	parameter int MAX_CHANNELS = acmn_pkg::MAX_CHANNELS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	acmn_in_if.sink               sample,
	acmn_out_if.source            result,
	input  wire logic             cfg_we,
	input  wire acmn_pkg::count_t cfg_data
);
	import acmn_pkg::*;

	cmd_t    cmd;
	status_t status;
	logic    in_ready;

	// The controller only steps the datapath; all data stays in acmn_dp.
	acmn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	assign sample.ready = in_ready;

	acmn_dp #(
		.MAX_CHANNELS (MAX_CHANNELS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_data       (cfg_data),
		.in_channel     (sample.channel),
		.in_high        (sample.high_byte),
		.in_low         (sample.low_byte),
		.cmd            (cmd),
		.status         (status),
		.res_ready      (result.ready),
		.res_valid      (result.valid),
		.res_channel    (result.out_channel),
		.res_fraction   (result.fraction),
		.res_calibrated (result.calibrated)
	);
endmodule
`default_nettype wire

[src/acmn_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module acmn_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic                                    re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule
`default_nettype wire

[src/acmn_ctrl.sv]
// Controller state machine that sequences lookup, update, division and output.
`default_nettype none
module acmn_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire acmn_pkg::status_t status,
	output acmn_pkg::cmd_t         cmd
);
	import acmn_pkg::*;

	state_t state_q;
	state_t state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) state_next = ST_LOOK;
			end
			ST_LOOK: begin
				state_next = status.active ? ST_DIV : ST_IDLE;
			end
			ST_DIV: begin
				if (status.div_done) state_next = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) state_next = ST_IDLE;
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.capture = in_valid;
			end
			ST_LOOK: begin
				cmd.update = status.active;
			end
			ST_DIV: begin
				cmd.step = !status.div_done;
			end
			ST_DONE: begin
				cmd.load_out = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end
endmodule
`default_nettype wire

[src/acmn_dp.sv]
// Datapath: limit store, min/max update, serial divider and result register.
`default_nettype none
module acmn_dp #(
	parameter int MAX_CHANNELS = acmn_pkg::MAX_CHANNELS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire acmn_pkg::count_t  cfg_data,
	input  wire acmn_pkg::chan_t   in_channel,
	input  wire acmn_pkg::byte_t   in_high,
	input  wire acmn_pkg::byte_t   in_low,
	input  wire acmn_pkg::cmd_t    cmd,
	output acmn_pkg::status_t      status,
	input  wire logic              res_ready,
	output logic                   res_valid,
	output acmn_pkg::chan_t        res_channel,
	output acmn_pkg::frac_t        res_fraction,
	output logic                   res_calibrated
);
	import acmn_pkg::*;

	localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	count_t                  count_q;
	logic [MAX_CHANNELS-1:0] seen_q;
	chan_t                   ch_q;
	raw_t                    raw_q;
	logic [AW-1:0]           addr_q;
	logic [2*RAW_W-1:0]      rd_data;
	raw_t                    lo_cur, hi_cur, lo_new, hi_new;
	raw_t                    diff, den;

	logic [FRAC_W-1:0]       rem_q;
	logic [FRAC_W-1:0]       quo_q;
	raw_t                    den_q;
	logic [DIV_CNT_W-1:0]    cnt_q;
	logic                    cal_q;
	logic [FRAC_W:0]         trial;
	logic [FRAC_W-1:0]       rem_keep;

	logic                    out_valid_q;
	chan_t                   out_ch_q;
	frac_t                   out_frac_q;
	logic                    out_cal_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= COUNT_RESET;
		end else if (cfg_we) begin
			count_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ch_q   <= in_channel;
			raw_q  <= {in_high, in_low};
			addr_q <= AW'(in_channel);
		end
	end

	// Limits live in RAM as {max, min}; an entry never written reads as reset limits.
	acmn_ram #(
		.WIDTH (2 * RAW_W),
		.DEPTH (MAX_CHANNELS)
	) u_limits (
		.clk   (clk),
		.we    (cmd.update),
		.waddr (addr_q),
		.wdata ({hi_new, lo_new}),
		.re    (cmd.capture),
		.raddr (AW'(in_channel)),
		.rdata (rd_data)
	);

	always_comb begin
		lo_cur = seen_q[addr_q] ? rd_data[RAW_W-1:0]       : MIN_RESET;
		hi_cur = seen_q[addr_q] ? rd_data[2*RAW_W-1:RAW_W] : MAX_RESET;
		lo_new = (raw_q < lo_cur) ? raw_q : lo_cur;
		hi_new = (raw_q > hi_cur) ? raw_q : hi_cur;
		diff   = raw_q - lo_new;
		den    = hi_new - lo_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (cmd.update) begin
			seen_q[addr_q] <= 1'b1;
		end
	end

	// Restoring divider, one quotient bit per step, most significant first.
	assign trial    = {1'b0, rem_q} - {2'b00, den_q};
	assign rem_keep = trial[FRAC_W] ? rem_q : trial[FRAC_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.update) begin
			cnt_q <= DIV_CNT_W'(DIV_STEPS);
		end else if (cmd.step) begin
			cnt_q <= cnt_q - DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			rem_q <= {1'b0, diff};
			quo_q <= '0;
			den_q <= den;
			cal_q <= (hi_new > lo_new);
		end else if (cmd.step) begin
			rem_q <= {rem_keep[FRAC_W-2:0], 1'b0};
			quo_q <= {quo_q[FRAC_W-2:0], !trial[FRAC_W]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_ch_q   <= ch_q;
			out_frac_q <= cal_q ? quo_q : '0;
			out_cal_q  <= cal_q;
		end
	end

	always_comb begin
		status.active   = ({1'b0, ch_q} < count_q) && (32'(ch_q) < MAX_CHANNELS);
		status.div_done = (cnt_q == '0);
		status.out_free = !out_valid_q || res_ready;
	end

	assign res_valid      = out_valid_q;
	assign res_channel    = out_ch_q;
	assign res_fraction   = out_frac_q;
	assign res_calibrated = out_cal_q;
endmodule
`default_nettype wire

[src/acmn_checker.sv]
// Port-level checker for the normalizer, bound to the top level.
`default_nettype none
module acmn_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            in_valid,
	input wire logic            in_ready,
	input wire logic            out_valid,
	input wire logic            out_ready,
	input wire acmn_pkg::frac_t out_fraction,
	input wire logic            out_calibrated
);
	import acmn_pkg::*;

	localparam frac_t ONE_Q16 = 17'h10000;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result item dropped while stalled");

	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_fraction <= ONE_Q16)
		else $error("fraction above 1.0");

	a_uncal_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_calibrated |-> out_fraction == '0)
		else $error("uncalibrated result with nonzero fraction");

	a_no_fast_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> !$past(in_valid && in_ready))
		else $error("result appeared right after an item was accepted");
endmodule

bind autocal_minmax_normalizer acmn_checker u_acmn_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (sample.valid),
	.in_ready       (sample.ready),
	.out_valid      (result.valid),
	.out_ready      (result.ready),
	.out_fraction   (result.fraction),
	.out_calibrated (result.calibrated)
);
`default_nettype wire
